/* rtl/core/ae16_pkg.sv */
// ----------------------------------------------------------------------------
// Arithmetic encoder package
// Beat types and function codes shared by the encoder and its users.
// ----------------------------------------------------------------------------
package ae16_pkg;

   localparam logic [1:0] FUNC_LOAD   = 2'd0;
   localparam logic [1:0] FUNC_ENCODE = 2'd1;
   localparam logic [1:0] FUNC_FLUSH  = 2'd2;

   localparam logic [15:0] TOTAL_CAP = 16'hfffe;
   localparam logic [15:0] COUNT_MAX = 16'hffff;

   typedef struct packed {
      logic [1:0]  func;
      logic [10:0] symbol;
      logic [7:0]  count;
   } req_type;

   typedef struct packed {
      logic        lead_bit;
      logic [15:0] follow_count;
      logic        last;
   } rsp_type;

endpackage

/* rtl/core/arithmetic_encoder_16bit_unit.sv */
// ----------------------------------------------------------------------------
// Sixteen-bit arithmetic encoder
// Static-model encoder: count loads build a cumulative table in memory,
// encode beats narrow the interval through a shared divider and renormalize
// one shift per cycle unless output stalls, flush beats emit the final run.
// ----------------------------------------------------------------------------
// Encode time is set by the table reads, two divisions on the
// two-bit-per-cycle divider and up to 16 renormalization shifts.
// One beat is worked on at a time; a waiting result does not block input.
// Synchronous reset restores the coder interval; the table is not cleared.
module arithmetic_encoder_16bit_unit #(
   parameter int SYMBOL_LIMIT = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ae16_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ae16_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [9:0]        csr_wdata
);
   import ae16_pkg::*;

   localparam int DEPTH = SYMBOL_LIMIT + 2;
   localparam int AW = $clog2(DEPTH);
   localparam logic [15:0] MAX_SYM = 16'(SYMBOL_LIMIT - 1);
   localparam logic [15:0] LIMIT16 = 16'(SYMBOL_LIMIT);

   typedef enum logic [3:0] {
      ST_IDLE, ST_LD_RD, ST_LD_WR, ST_EN_G, ST_EN_L, ST_EN_H, ST_EN_U,
      ST_EN_DIV, ST_EN_REN, ST_EN_END, ST_FLUSH
   } state_type;

   state_type   state_ff;
   logic [9:0]  max_symbol_ff;
   logic [15:0] low_ff, high_ff, under_ff;
   logic [15:0] sym_ff;
   logic [7:0]  cnt_ff;
   logic [15:0] grand_ff, lower_ff, qhi_ff, q_ff, rem_ff;
   logic [33:0] div_ff;
   logic [4:0]  step_ff;
   logic        phase_ff;
   logic        pend_valid_ff;
   rsp_type     pend_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   logic [15:0] mem [DEPTH];
   logic [15:0] mem_q_ff;
   logic        zero_ff;
   logic [AW-1:0] rd_addr;
   logic [15:0] rdata;

   logic [15:0] m16, m1, req_sym16;
   logic [16:0] range17, sum17, t1, t2;
   logic [15:0] upper_sel, mul_b, r1, r2;
   logic [32:0] product;
   logic        ge1, ge2, out_free, top_eq, under;
   logic [15:0] q_next, under_inc;

   assign m16 = ({6'd0, max_symbol_ff} > MAX_SYM) ? MAX_SYM : {6'd0, max_symbol_ff};
   assign m1 = m16 + 16'd1;
   assign req_sym16 = {5'd0, req_data.symbol};
   assign rdata = zero_ff ? 16'd0 : mem_q_ff;

   always_comb begin
      unique case (state_ff)
         ST_EN_G: rd_addr = m1[AW-1:0];
         ST_EN_H: rd_addr = AW'(sym_ff + 16'd1);
         default: rd_addr = sym_ff[AW-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      mem_q_ff <= mem[rd_addr];
      zero_ff <= (rd_addr == '0);
      if (state_ff == ST_LD_WR) begin
         mem[AW'(sym_ff + 16'd1)] <= (sum17 > {1'b0, TOTAL_CAP}) ? TOTAL_CAP : sum17[15:0];
      end
   end

   assign sum17 = {1'b0, rdata} + {9'd0, cnt_ff};
   assign range17 = {1'b0, high_ff} - {1'b0, low_ff} + 17'd1;
   assign upper_sel = (sym_ff == m1) ? grand_ff : rdata;
   assign mul_b = (state_ff == ST_EN_U) ? upper_sel : lower_ff;
   assign product = range17 * {17'd0, mul_b};

   assign t1 = {rem_ff, div_ff[33]};
   assign ge1 = t1 >= {1'b0, grand_ff};
   assign r1 = ge1 ? 16'(t1 - {1'b0, grand_ff}) : t1[15:0];
   assign t2 = {r1, div_ff[32]};
   assign ge2 = t2 >= {1'b0, grand_ff};
   assign r2 = ge2 ? 16'(t2 - {1'b0, grand_ff}) : t2[15:0];
   assign q_next = {q_ff[13:0], ge1, ge2};

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign top_eq = (high_ff[15] == low_ff[15]);
   assign under = low_ff[14] && !high_ff[14];
   assign under_inc = (under_ff == COUNT_MAX) ? COUNT_MAX : under_ff + 16'd1;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         max_symbol_ff <= '0;
         low_ff <= '0;
         high_ff <= 16'hffff;
         under_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            max_symbol_ff <= csr_wdata;
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  sym_ff <= req_sym16;
                  cnt_ff <= req_data.count;
                  if (req_data.func == FUNC_LOAD && req_sym16 < LIMIT16) begin
                     state_ff <= ST_LD_RD;
                  end else if (req_data.func == FUNC_ENCODE && req_sym16 <= m1) begin
                     state_ff <= ST_EN_G;
                  end else if (req_data.func == FUNC_FLUSH) begin
                     state_ff <= ST_FLUSH;
                  end
               end
            end
            ST_LD_RD: state_ff <= ST_LD_WR;
            ST_LD_WR: state_ff <= ST_IDLE;
            ST_EN_G: state_ff <= ST_EN_L;
            ST_EN_L: begin
               grand_ff <= rdata + 16'd1;
               state_ff <= ST_EN_H;
            end
            ST_EN_H: begin
               lower_ff <= rdata;
               state_ff <= ST_EN_U;
            end
            ST_EN_U: begin
               div_ff <= {1'b0, product};
               rem_ff <= '0;
               step_ff <= '0;
               phase_ff <= 1'b0;
               state_ff <= ST_EN_DIV;
            end
            ST_EN_DIV: begin
               div_ff <= {div_ff[31:0], 2'b00};
               rem_ff <= r2;
               q_ff <= q_next;
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'd16) begin
                  if (!phase_ff) begin
                     qhi_ff <= q_next;
                     div_ff <= {1'b0, product};
                     rem_ff <= '0;
                     step_ff <= '0;
                     phase_ff <= 1'b1;
                  end else begin
                     high_ff <= low_ff + qhi_ff - 16'd1;
                     low_ff <= low_ff + q_next;
                     step_ff <= '0;
                     state_ff <= ST_EN_REN;
                  end
               end
            end
            ST_EN_REN: begin
               if (step_ff == 5'd16) begin
                  state_ff <= ST_EN_END;
               end else if (top_eq) begin
                  if (!pend_valid_ff || out_free) begin
                     if (pend_valid_ff) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_data_ff <= pend_ff;
                     end
                     pend_valid_ff <= 1'b1;
                     pend_ff <= '{lead_bit: high_ff[15], follow_count: under_ff, last: 1'b0};
                     under_ff <= '0;
                     low_ff <= {low_ff[14:0], 1'b0};
                     high_ff <= {high_ff[14:0], 1'b1};
                     step_ff <= step_ff + 5'd1;
                  end
               end else if (under) begin
                  under_ff <= under_inc;
                  low_ff <= {1'b0, low_ff[13:0], 1'b0};
                  high_ff <= {1'b1, high_ff[13:0], 1'b1};
                  step_ff <= step_ff + 5'd1;
               end else begin
                  state_ff <= ST_EN_END;
               end
            end
            ST_EN_END: begin
               if (!pend_valid_ff) begin
                  state_ff <= ST_IDLE;
               end else if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff <= '{lead_bit: pend_ff.lead_bit,
                                   follow_count: pend_ff.follow_count, last: 1'b1};
                  pend_valid_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            ST_FLUSH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff <= '{lead_bit: low_ff[14], follow_count: under_inc, last: 1'b1};
                  low_ff <= '0;
                  high_ff <= 16'hffff;
                  under_ff <= '0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
